@@ rtl/lrbc_pkg.sv @@
// Package for the LED ramp and breathe controller.
// Holds field widths, phase, drive and follow-on codes, and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package lrbc_pkg;

  localparam int LevelW = 8;
  localparam int CfgIdxW = 2;

  typedef logic [LevelW-1:0] level_t;

  // Controller phase
  typedef enum logic [1:0] {
    PH_OFF  = 2'd0,
    PH_ON   = 2'd1,
    PH_RAMP = 2'd2,
    PH_OSC  = 2'd3
  } phase_t;

  // LED driver mode
  typedef enum logic [1:0] {
    DRV_AUTO = 2'd0,
    DRV_ON   = 2'd1,
    DRV_OFF  = 2'd2,
    DRV_RSVD = 2'd3
  } drive_t;

  // Phase to take when a ramp reaches its goal
  typedef enum logic [1:0] {
    AR_OFF  = 2'd0,
    AR_ON   = 2'd1,
    AR_RSVD = 2'd2,
    AR_NONE = 2'd3
  } after_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_LEVEL_LOW  = 2'd0,
    REG_LEVEL_HIGH = 2'd1,
    REG_LEVEL_STEP = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  // Item kinds
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_STATUS = 1'b1;

  localparam level_t LEVEL_LOW_RST = 8'd0;
  localparam level_t LEVEL_HIGH_RST = 8'd255;
  localparam level_t LEVEL_STEP_RST = 8'd13;

endpackage

@@ rtl/lrbc_if.sv @@
// Handshake channels of the LED ramp and breathe controller:
// status/tick requests, results and configuration writes.
// Depends on lrbc_pkg.
`timescale 1ns / 1ps

interface lrbc_item_if;
  logic valid;
  logic ready;
  logic mode;
  logic powered;
  logic charging;

  modport source (output valid, output mode, output powered, output charging,
                  input ready);
  modport sink (input valid, input mode, input powered, input charging,
                output ready);
endinterface

interface lrbc_result_if;
  logic                    valid;
  logic                    ready;
  logic [7:0]              pwm_level;
  logic [1:0]              drive_mode;
  logic [1:0]              phase;

  modport source (output valid, output pwm_level, output drive_mode, output phase,
                  input ready);
  modport sink (input valid, input pwm_level, input drive_mode, input phase,
                output ready);
endinterface

interface lrbc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lrbc_pkg::CfgIdxW-1:0] index;
  logic [lrbc_pkg::LevelW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/led_ramp_breathe_controller.sv @@
// Top level of the LED ramp and breathe controller.
// Depends on lrbc_pkg and the channel interfaces in lrbc_if.sv.
`timescale 1ns / 1ps

// Usage
//   status_in : one request per item. mode 0 is a tick that steps the level,
//               mode 1 is a power status report (powered, charging).
//   result_out: one result per request: pwm_level (gamma mapped level),
//               drive_mode (1 forced on, 2 forced off) and phase.
//   cfg       : register writes, index 0 level_low, 1 level_high,
//               2 level_step; always ready. Write only while idle.
// Timing
//   The controller state updates in the cycle a request is taken; a second
//   stage squares the level and maps it to the drive level. A result
//   passes through the state registers and then the result register.
//   One request per cycle is taken as long as the result side keeps up.
// Reset (rst, synchronous) gives phase off, drive forced off, level 0 and
// the register defaults 0 / 255 / 13.
// When the receiver stalls with a result waiting, status_in.ready drops in
// the same cycle and the controller state and the stage before the result
// register hold until the result is taken.
module led_ramp_breathe_controller (
  input logic     clk,
  input logic     rst,
  lrbc_item_if.sink   status_in,
  lrbc_result_if.source result_out,
  lrbc_cfg_if.sink    cfg
);
  import lrbc_pkg::*;

  // configuration registers
  level_t level_low;
  level_t level_high;
  level_t level_step;

  // controller state
  phase_t phase_st,   phase_next;
  after_t after_ramp, after_ramp_next;
  level_t level,      level_next;
  level_t goal,       goal_next;
  level_t swing_base, swing_base_next;
  drive_t drive,      drive_next;

  // pipeline control and result registers
  logic       stage_valid;
  logic       out_valid;
  logic       advance;
  logic       accept;
  level_t     pwm_level;
  drive_t     drive_mode;
  phase_t     phase_out;
  logic [15:0] square;
  logic [16:0] scaled;

  assign advance = !out_valid || result_out.ready;
  assign status_in.ready = advance;
  assign accept = status_in.valid && advance;
  assign cfg.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      level_low <= LEVEL_LOW_RST;
      level_high <= LEVEL_HIGH_RST;
      level_step <= LEVEL_STEP_RST;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_LEVEL_LOW:  level_low <= cfg.data;
        REG_LEVEL_HIGH: level_high <= cfg.data;
        REG_LEVEL_STEP: level_step <= cfg.data;
        default: ;
      endcase
    end
  end

  // next controller state for one request
  always_comb begin
    logic       run;
    level_t     ramp_on_goal;
    logic [8:0] up_sum;
    level_t     diff;
    ramp_on_goal = level_high >> 2;
    phase_next = phase_st;
    after_ramp_next = after_ramp;
    level_next = level;
    goal_next = goal;
    swing_base_next = swing_base;
    drive_next = drive;
    run = 1'b0;
    up_sum = '0;
    diff = '0;

    // pick the request, ignore one already under way
    if (status_in.mode == MODE_STATUS) begin
      if (status_in.powered && status_in.charging) begin
        if (phase_st != PH_OSC) begin
          phase_next = PH_OSC;
          goal_next = level_high;
          swing_base_next = level_low;
          run = 1'b1;
        end
      end else if (status_in.powered) begin
        if (phase_st != PH_ON &&
            !(phase_st == PH_RAMP && after_ramp == AR_ON && goal == ramp_on_goal)) begin
          phase_next = PH_RAMP;
          goal_next = ramp_on_goal;
          after_ramp_next = AR_ON;
          run = 1'b1;
        end
      end else begin
        if (phase_st != PH_OFF &&
            !(phase_st == PH_RAMP && after_ramp == AR_OFF && goal == '0)) begin
          phase_next = PH_RAMP;
          goal_next = '0;
          after_ramp_next = AR_OFF;
          run = 1'b1;
        end
      end
    end else begin
      run = 1'b1;
    end

    // tick work
    if (run) begin
      if (phase_next == PH_OFF || phase_next == PH_ON) begin
        drive_next = (phase_next == PH_OFF) ? DRV_OFF : DRV_ON;
        if (after_ramp_next != AR_NONE) begin
          phase_next = phase_t'(after_ramp_next);
          after_ramp_next = AR_NONE;
        end
      end else begin
        if (drive_next != DRV_ON) begin
          drive_next = DRV_ON;
          level_next = '0;
        end
        // step toward goal, clip there
        up_sum = {1'b0, level_next} + {1'b0, level_step};
        diff = level_next - goal_next;
        if (level_next < goal_next) begin
          level_next = (up_sum > {1'b0, goal_next}) ? goal_next : up_sum[7:0];
        end else if (level_next > goal_next) begin
          level_next = (level_step >= diff) ? goal_next : level_next - level_step;
        end
        if (level_next == goal_next) begin
          if (phase_next == PH_RAMP) begin
            if (after_ramp_next != AR_NONE) begin
              phase_next = phase_t'(after_ramp_next);
              after_ramp_next = AR_NONE;
            end
          end else begin
            goal_next = swing_base_next;
            swing_base_next = goal;
            if (phase_st != PH_OSC) begin
              swing_base_next = level_high;
            end
          end
        end
      end
    end
  end

  // hold state, advance on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_st <= PH_OFF;
      after_ramp <= AR_NONE;
      level <= '0;
      goal <= '0;
      swing_base <= '0;
      drive <= DRV_OFF;
    end else if (accept) begin
      phase_st <= phase_next;
      after_ramp <= after_ramp_next;
      level <= level_next;
      goal <= goal_next;
      swing_base <= swing_base_next;
      drive <= drive_next;
    end
  end

  // gamma map: floor(p / 255) for p the square of the 8-bit level
  assign square = level * level;
  assign scaled = {1'b0, square} + {9'd0, square[15:8]} + 17'd1;

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      stage_valid <= accept;
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      pwm_level <= scaled[15:8];
      drive_mode <= drive;
      phase_out <= phase_st;
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.pwm_level = pwm_level;
  assign result_out.drive_mode = drive_mode;
  assign result_out.phase = phase_out;

`ifndef SYNTH
  // the controller never hands out auto drive
  a_no_auto_drive: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> (result_out.drive_mode == DRV_ON ||
                          result_out.drive_mode == DRV_OFF))
    else $error("result carries a drive mode other than on or off");

  // forced-off drive only happens with the level at zero
  a_off_dark: assert property (@(posedge clk) disable iff (rst)
    (drive == DRV_OFF) |-> (level == '0))
    else $error("drive forced off with a nonzero level");

  // state moves only on an accepted request
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(level) && $stable(phase_st) && $stable(drive)))
    else $error("controller state changed without a request");

  // an empty result register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> status_in.ready)
    else $error("input stalled with an empty result register");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the LED ramp and breathe controller.
// Predicts phase, drive mode and gamma-mapped level per request and checks each result.
// Depends on lrbc_pkg, the channel interfaces in lrbc_if.sv and the controller RTL.
`timescale 1ns / 1ps

module tb_top;
  import lrbc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned MAX_REPORTS = 40;

  // Receiver stall patterns
  localparam int RX_FULL = 0;
  localparam int RX_HALF = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_MOSTLY = 3;

  typedef struct packed {
    level_t pwm;
    drive_t drive;
    phase_t phase;
  } led_result_t;

  logic clk = 1'b0;
  logic rst;

  lrbc_item_if status_if ();
  lrbc_result_if result_if ();
  lrbc_cfg_if cfg_if ();

  led_ramp_breathe_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .status_in (status_if),
    .result_out(result_if),
    .cfg       (cfg_if)
  );

  // Controller state and registers as the block should hold them
  phase_t ctl_phase = PH_OFF;
  after_t ctl_after = AR_NONE;
  level_t ctl_level = '0;
  level_t ctl_goal = '0;
  level_t ctl_swing = '0;
  drive_t ctl_drive = DRV_OFF;
  level_t cfg_low = LEVEL_LOW_RST;
  level_t cfg_high = LEVEL_HIGH_RST;
  level_t cfg_step = LEVEL_STEP_RST;

  led_result_t expected_leds[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 1;
  int unsigned hold_left = 0;

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Move the level one step toward its goal, clipping at the goal
  function automatic level_t step_toward(input level_t lv, input level_t g, input level_t s);
    int sum;
    sum = int'(lv) + int'(s);
    if (lv < g) return (sum > int'(g)) ? g : level_t'(sum);
    if (lv > g) return (int'(s) >= int'(lv) - int'(g)) ? g : level_t'(lv - s);
    return lv;
  endfunction

  function automatic void advance_tick();
    level_t held;
    if (ctl_phase == PH_OFF || ctl_phase == PH_ON) begin
      ctl_drive = (ctl_phase == PH_OFF) ? DRV_OFF : DRV_ON;
      if (ctl_after != AR_NONE) begin
        ctl_phase = phase_t'(ctl_after);
        ctl_after = AR_NONE;
      end
      return;
    end
    // Turning the driver on restarts the level from zero
    if (ctl_drive != DRV_ON) begin
      ctl_drive = DRV_ON;
      ctl_level = '0;
    end
    ctl_level = step_toward(ctl_level, ctl_goal, cfg_step);
    if (ctl_level == ctl_goal) begin
      if (ctl_phase == PH_RAMP) begin
        if (ctl_after != AR_NONE) begin
          ctl_phase = phase_t'(ctl_after);
          ctl_after = AR_NONE;
        end
      end else begin
        held = ctl_goal;
        ctl_goal = ctl_swing;
        ctl_swing = held;
      end
    end
  endfunction

  // Pick the new phase from a status report; drop requests already under way
  function automatic void apply_status(input bit powered, input bit charging);
    level_t on_goal;
    on_goal = cfg_high >> 2;
    if (powered && charging) begin
      if (ctl_phase != PH_OSC) begin
        ctl_phase = PH_OSC;
        ctl_goal = cfg_high;
        ctl_swing = cfg_low;
        advance_tick();
      end
    end else if (powered) begin
      if (ctl_phase != PH_ON &&
          !(ctl_phase == PH_RAMP && ctl_after == AR_ON && ctl_goal == on_goal)) begin
        ctl_phase = PH_RAMP;
        ctl_goal = on_goal;
        ctl_after = AR_ON;
        advance_tick();
      end
    end else begin
      if (ctl_phase != PH_OFF &&
          !(ctl_phase == PH_RAMP && ctl_after == AR_OFF && ctl_goal == '0)) begin
        ctl_phase = PH_RAMP;
        ctl_goal = '0;
        ctl_after = AR_OFF;
        advance_tick();
      end
    end
  endfunction

  function automatic void predict_led(input logic m, input logic powered, input logic charging);
    led_result_t r;
    if (m == MODE_STATUS) apply_status(powered, charging);
    else advance_tick();
    r.pwm = level_t'((int'(ctl_level) * int'(ctl_level)) / 255);
    r.drive = ctl_drive;
    r.phase = ctl_phase;
    expected_leds.push_back(r);
  endfunction

  // Offer one request, wait for it to be taken, then maybe idle between bursts
  task automatic send_request(input logic m, input logic powered, input logic charging);
    status_if.valid <= 1'b1;
    status_if.mode <= m;
    status_if.powered <= powered;
    status_if.charging <= charging;
    do @(posedge clk); while (status_if.ready !== 1'b1);
    predict_led(m, powered, charging);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      status_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 16);
    end
  endtask

  task automatic send_tick();
    send_request(MODE_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    status_if.valid <= 1'b0;
    do @(posedge clk); while (expected_leds.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input level_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_LEVEL_LOW: cfg_low = value;
      REG_LEVEL_HIGH: cfg_high = value;
      REG_LEVEL_STEP: cfg_step = value;
      default: ;
    endcase
  endtask

  // Reprogram all levels once the block has drained
  task automatic write_levels(input level_t lo, input level_t hi, input level_t st,
                              input bit touch_unused);
    wait_idle();
    write_reg(REG_LEVEL_LOW, lo);
    write_reg(REG_LEVEL_HIGH, hi);
    write_reg(REG_LEVEL_STEP, st);
    if (touch_unused) write_reg(REG_UNUSED, level_t'($urandom_range(0, 255)));
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly a status report followed by a run of ticks, sometimes a lone request
  task automatic run_mixed(input int unsigned count);
    int unsigned sent;
    int unsigned run_len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) != 0) begin
        send_request(MODE_STATUS, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        run_len = $urandom_range(0, 30);
        repeat (run_len) send_tick();
        sent += run_len + 1;
      end else begin
        send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  task automatic test_off_after_reset();
    send_tick();
    send_request(MODE_STATUS, 1'b0, 1'b0);
    send_request(MODE_STATUS, 1'b0, 1'b1);
    send_request(MODE_TICK, 1'b1, 1'b1);
  endtask

  task automatic test_powered_ramp_to_on();
    send_request(MODE_STATUS, 1'b1, 1'b0);
    send_request(MODE_STATUS, 1'b1, 1'b0);
    repeat (5) send_tick();
    send_request(MODE_STATUS, 1'b1, 1'b0);
    send_tick();
  endtask

  task automatic test_charging_breathe();
    write_levels(8'd0, 8'd255, 8'd128, 1'b0);
    send_request(MODE_STATUS, 1'b1, 1'b1);
    send_request(MODE_STATUS, 1'b1, 1'b1);
    repeat (4) send_tick();
    send_request(MODE_STATUS, 1'b0, 1'b0);
    repeat (2) send_tick();
  endtask

  // Hold the result side off long enough that the block backs up its input
  task automatic test_input_stall();
    wait_idle();
    burst_left = 1000;
    hold_left = 400;
    run_mixed(60);
    burst_left = 4;
  endtask

  task automatic test_random_settings();
    write_levels(8'd0, 8'd255, 8'd255, 1'b0);
    run_mixed(275);
    write_levels(8'd255, 8'd0, 8'd1, 1'b1);
    run_mixed(275);
    // Zero step: the level stays where it is
    write_levels(8'd37, 8'd200, 8'd0, 1'b0);
    run_mixed(150);
    repeat (4) begin
      write_levels(level_t'($urandom_range(0, 255)), level_t'($urandom_range(0, 255)),
                   level_t'(($urandom_range(0, 1) == 1) ? $urandom_range(1, 20)
                                                         : $urandom_range(1, 255)),
                   1'b0);
      run_mixed(200);
    end
  endtask

  // Check each taken result against the oldest prediction
  always @(posedge clk) begin : result_checker
    led_result_t want;
    if (rst === 1'b0 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (expected_leds.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = expected_leds.pop_front();
        if (result_if.pwm_level !== want.pwm)
          report_mismatch($sformatf("pwm_level %0d, want %0d", result_if.pwm_level, want.pwm));
        if (result_if.drive_mode !== want.drive)
          report_mismatch($sformatf("drive_mode %0d, want %0d", result_if.drive_mode,
                                    want.drive));
        if (result_if.phase !== want.phase)
          report_mismatch($sformatf("phase %0d, want %0d", result_if.phase, want.phase));
      end
    end
  end

  // Receiver: switch between stall patterns, or hold off when asked
  initial begin : result_receiver
    int pattern;
    int unsigned pattern_left;
    pattern = RX_FULL;
    pattern_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern = $urandom_range(RX_FULL, RX_MOSTLY);
          pattern_left = $urandom_range(20, 150);
        end
        pattern_left--;
        case (pattern)
          RX_FULL: result_if.ready <= 1'b1;
          RX_HALF: result_if.ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: result_if.ready <= ($urandom_range(0, 3) == 0);
          default: result_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : test_sequence
    rst <= 1'b1;
    status_if.valid <= 1'b0;
    status_if.mode <= MODE_TICK;
    status_if.powered <= 1'b0;
    status_if.charging <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_LEVEL_LOW;
    cfg_if.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_off_after_reset();
    test_powered_ramp_to_on();
    test_charging_breathe();
    test_input_stall();
    test_random_settings();

    // Drain, then give any stray result time to show
    wait_idle();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
